// ===== rtl/sfla_pkg.sv =====
// Shared constants, payload types and codes of the segregated free-list allocator.
`timescale 1ns / 1ps

package sfla_pkg;

  // Sizing
  localparam int unsigned SIZE_CLASSES = 512;
  localparam int unsigned BLOCK_UNITS  = 4096;
  localparam int unsigned MAX_BLOCKS   = 16;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned CLASS_W  = $clog2(SIZE_CLASSES);
  localparam int unsigned BUMP_W   = $clog2(BLOCK_UNITS + 1);
  localparam int unsigned BLK_W    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned CMP_W    = ((BLK_W > LIMIT_W) ? BLK_W : LIMIT_W) + 1;
  localparam int unsigned UNITS_W  = 17;
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned ENTRY_W  = ADDR_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [UNITS_W-1:0] UNITS_MAX = {UNITS_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 2'd1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_SIZE_ZERO = 3'd1,
    STAT_SYSTEM    = 3'd2,
    STAT_LIMIT     = 3'd3,
    STAT_EXHAUSTED = 3'd4,
    STAT_TOO_BIG   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_HEAD  = 2'd2,
    ST_LINK  = 2'd3
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address_res;
    status_e            status;
    logic [UNITS_W-1:0] bytes_reserved;
    logic [REQ_W-1:0]   request_count;
  } out_item_t;

endpackage

// ===== rtl/segregated_free_list_allocator.sv =====
// Segregated free-list allocator: per-class LIFO lists in RAM plus a bump pointer.
`timescale 1ns / 1ps

// After reset the block sweeps the list-head RAM, one class per cycle, over all SIZE_CLASSES
// classes (512) and accepts no item meanwhile; configuration writes are taken at any time.
// After that one item is handled at a time. An item is taken in one cycle and its list head
// is read from the head RAM in the next; frees, bump allocations and all special statuses
// finish there, once the output register is free. Popping a free list needs a second
// synchronous read, from the link RAM. A result waits in an output register; a new item
// is taken while it waits, but the next result is held until the previous one has gone.
// Allocation addresses wrap modulo 2^16.
module segregated_free_list_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sfla_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sfla_pkg::out_item_t       out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sfla_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfla_pkg::LIMIT_W-1:0]   cfg_data_i
);
  import sfla_pkg::*;

  // Configuration
  logic               limit_en_q;
  logic [LIMIT_W-1:0] block_limit_q;

  // Control and counters
  state_e             state_q, state_d;
  logic [CLASS_W-1:0] clr_q, clr_d;
  logic               block_open_q, block_open_d;
  logic [BUMP_W-1:0]  bump_q, bump_d;
  logic [BLK_W-1:0]   blocks_q, blocks_d;
  logic [UNITS_W-1:0] units_q, units_d;
  logic [REQ_W-1:0]   reqs_q, reqs_d;

  // Item in flight and result register
  in_item_t           item_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;

  // Memory ports
  logic [ENTRY_W-1:0] head_mem [SIZE_CLASSES];
  logic               head_we, head_re;
  logic [CLASS_W-1:0] head_waddr, head_raddr;
  logic [ENTRY_W-1:0] head_wdata, head_rdata_q;

  logic [ENTRY_W-1:0] link_mem [2**ADDR_W];
  logic               link_we, link_re;
  logic [ADDR_W-1:0]  link_waddr, link_raddr;
  logic [ENTRY_W-1:0] link_wdata, link_rdata_q;

  // Decode
  logic               accept, out_free, out_load;
  out_item_t          res;
  logic               size_zero, size_small, head_hit, too_big, need_new;
  logic               over_limit, exhausted;
  logic [BUMP_W-1:0]  bump_base;
  logic [BLK_W-1:0]   blocks_new, blk_idx;
  logic [31:0]        block_base;
  logic [ADDR_W-1:0]  bump_chunk;
  logic [UNITS_W:0]   units_sum;
  logic [UNITS_W-1:0] units_sat;
  logic [UNITS_W-1:0] bump_sum;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Item classification
  assign size_zero  = (item_q.size == '0);
  assign size_small = (item_q.size < SIZE_W'(SIZE_CLASSES));
  assign head_hit   = head_rdata_q[ENTRY_W-1];
  assign too_big    = (17'(item_q.size) > 17'(BLOCK_UNITS));
  assign need_new   = !block_open_q ||
                      ((17'(BLOCK_UNITS) - 17'(bump_q)) < 17'(item_q.size));
  assign over_limit = limit_en_q &&
                      ((CMP_W'(blocks_q) + CMP_W'(1)) > CMP_W'(block_limit_q));
  assign exhausted  = (32'(blocks_q) >= 32'(MAX_BLOCKS));

  // Bump address: start of the current block plus the offset inside it
  assign bump_base  = need_new ? '0 : bump_q;
  assign blocks_new = need_new ? blocks_q + BLK_W'(1) : blocks_q;
  assign blk_idx    = blocks_new - BLK_W'(1);
  assign block_base = 32'(blk_idx) * 32'(BLOCK_UNITS);
  assign bump_chunk = ADDR_W'(block_base + 32'(bump_base));
  assign bump_sum   = 17'(bump_base) + 17'(item_q.size);
  assign units_sum  = 18'(units_q) + 18'(item_q.size);
  assign units_sat  = (units_sum > 18'(UNITS_MAX)) ? UNITS_MAX : units_sum[UNITS_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLASS_W'(SIZE_CLASSES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        if (out_free) begin
          if (!size_zero && size_small && item_q.command == CMD_ALLOC && head_hit) begin
            state_d = ST_LINK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LINK: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Memory controls, result and state updates
  always_comb begin
    head_we      = 1'b0;
    head_waddr   = item_q.size[CLASS_W-1:0];
    head_wdata   = '0;
    head_re      = 1'b0;
    head_raddr   = in_item_i.size[CLASS_W-1:0];
    link_we      = 1'b0;
    link_waddr   = item_q.address;
    link_wdata   = head_rdata_q;
    link_re      = 1'b0;
    link_raddr   = head_rdata_q[ADDR_W-1:0];
    clr_d        = clr_q;
    block_open_d = block_open_q;
    bump_d       = bump_q;
    blocks_d     = blocks_q;
    units_d      = units_q;
    reqs_d       = reqs_q;
    out_load     = 1'b0;
    res          = '{address_res: '0, status: STAT_OK,
                     bytes_reserved: units_q, request_count: reqs_q};
    case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d      = clr_q + CLASS_W'(1);
      end
      ST_IDLE: begin
        head_re = accept;
      end
      ST_HEAD: begin
        if (out_free) begin
          if (size_zero) begin
            out_load   = 1'b1;
            res.status = STAT_SIZE_ZERO;
          end else if (item_q.command == CMD_FREE) begin
            out_load = 1'b1;
            if (!size_small) begin
              res.status = STAT_SYSTEM;
            end else begin
              // push: old head becomes the chunk's link
              link_we    = 1'b1;
              head_we    = 1'b1;
              head_wdata = {1'b1, item_q.address};
            end
          end else if (!size_small) begin
            out_load          = 1'b1;
            reqs_d            = reqs_q + REQ_W'(1);
            res.status        = STAT_SYSTEM;
            res.request_count = reqs_d;
          end else if (head_hit) begin
            link_re = 1'b1;
          end else begin
            out_load = 1'b1;
            if (need_new && too_big) begin
              res.status = STAT_TOO_BIG;
            end else if (need_new && over_limit) begin
              res.status = STAT_LIMIT;
            end else if (need_new && exhausted) begin
              res.status = STAT_EXHAUSTED;
            end else begin
              block_open_d       = 1'b1;
              blocks_d           = blocks_new;
              bump_d             = BUMP_W'(bump_sum);
              units_d            = units_sat;
              reqs_d             = reqs_q + REQ_W'(1);
              res.address_res    = bump_chunk;
              res.bytes_reserved = units_d;
              res.request_count  = reqs_d;
            end
          end
        end
      end
      ST_LINK: begin
        if (out_free) begin
          // pop: the link of the head chunk becomes the new head
          out_load          = 1'b1;
          head_we           = 1'b1;
          head_wdata        = link_rdata_q;
          reqs_d            = reqs_q + REQ_W'(1);
          res.address_res   = head_rdata_q[ADDR_W-1:0];
          res.request_count = reqs_d;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      block_open_q  <= 1'b0;
      bump_q        <= '0;
      blocks_q      <= '0;
      units_q       <= '0;
      reqs_q        <= '0;
      out_valid_q   <= 1'b0;
      limit_en_q    <= 1'b1;
      block_limit_q <= LIMIT_W'(16);
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      block_open_q <= block_open_d;
      bump_q       <= bump_d;
      blocks_q     <= blocks_d;
      units_q      <= units_d;
      reqs_q       <= reqs_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LIMIT_EN:    limit_en_q    <= cfg_data_i[0];
          CFG_BLOCK_LIMIT: block_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (out_load) out_q <= res;
  end

  // List-head RAM
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_rdata_q <= head_mem[head_raddr];
  end

  // Link RAM, indexed by chunk address
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) link_rdata_q <= link_mem[link_raddr];
  end

  // Checks
  a_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_HEAD || state_q == ST_LINK))
    else $error("result loaded outside a working state");

  a_fatal_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res.status == STAT_LIMIT || res.status == STAT_EXHAUSTED ||
                  res.status == STAT_TOO_BIG))
    |=> (reqs_q == $past(reqs_q) && blocks_q == $past(blocks_q) &&
         units_q == $past(units_q)))
    else $error("fatal status changed allocator state");

  a_blocks_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(blocks_q) <= 32'(MAX_BLOCKS))
    else $error("more blocks opened than exist");

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_open_q |-> (blocks_q != '0))
    else $error("block open with no block counted");

  a_link_after_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> ($past(state_q) == ST_HEAD || $past(state_q) == ST_LINK))
    else $error("link read without a head read");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the segregated free-list allocator.
`timescale 1ns / 1ps

module tb;
  import sfla_pkg::*;

  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned FINAL_SETTLE = 20;
  localparam int unsigned MAX_IDLE = 6;

  // Clock, reset and block inputs, all known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segregated_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shared run control
  bit          failed = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned hold_off_cycles = 0;
  status_e     last_status = STAT_OK;

  // Predicted allocator state and settings
  logic [ENTRY_W-1:0] head_table [SIZE_CLASSES];
  logic [ENTRY_W-1:0] link_table [1 << ADDR_W];
  logic               block_is_open = 1'b0;
  int unsigned        bump_offset = 0;
  int unsigned        blocks_used = 0;
  int unsigned        units_taken = 0;
  logic [REQ_W-1:0]   alloc_requests = '0;
  logic               limit_on = 1'b1;
  logic [LIMIT_W-1:0] block_cap = 5'd16;

  // Results still owed by the block, oldest first
  out_item_t expected_results [$];

  // Chunks handed out and not yet freed, used to build well-formed frees
  logic [ADDR_W-1:0] live_addr_pool [$];
  logic [SIZE_W-1:0] live_size_pool [$];

  // Predicts the result of one request and updates the predicted state
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t   res;
    logic        need_block;
    logic [31:0] full_addr;
    res.address_res = '0;
    res.status      = STAT_OK;
    if (req.size == '0) begin
      res.status = STAT_SIZE_ZERO;
    end else if (req.command == CMD_FREE) begin
      if (req.size >= SIZE_CLASSES) begin
        res.status = STAT_SYSTEM;
      end else begin
        // push on the class list, address unchecked
        link_table[req.address] = head_table[req.size];
        head_table[req.size]    = {1'b1, req.address};
      end
    end else if (req.size >= SIZE_CLASSES) begin
      res.status = STAT_SYSTEM;
      alloc_requests++;
    end else if (head_table[req.size][ADDR_W]) begin
      // pop the list head
      res.address_res      = head_table[req.size][ADDR_W-1:0];
      head_table[req.size] = link_table[res.address_res];
      alloc_requests++;
    end else begin
      // bump allocation, opening a new block when the request does not fit
      need_block = !block_is_open || (BLOCK_UNITS - bump_offset < req.size);
      if (need_block && req.size > BLOCK_UNITS) begin
        res.status = STAT_TOO_BIG;
      end else if (need_block && limit_on && blocks_used + 1 > block_cap) begin
        res.status = STAT_LIMIT;
      end else if (need_block && blocks_used >= MAX_BLOCKS) begin
        res.status = STAT_EXHAUSTED;
      end else begin
        if (need_block) begin
          blocks_used++;
          block_is_open = 1'b1;
          bump_offset   = 0;
        end
        full_addr       = (blocks_used - 1) * BLOCK_UNITS + bump_offset;
        res.address_res = full_addr[ADDR_W-1:0];
        bump_offset += req.size;
        units_taken = (units_taken + req.size > UNITS_MAX) ? UNITS_MAX
                                                           : units_taken + req.size;
        alloc_requests++;
      end
    end
    res.bytes_reserved = UNITS_W'(units_taken);
    res.request_count  = alloc_requests;
    return res;
  endfunction

  function automatic in_item_t make_request(cmd_e command, int unsigned size,
                                            logic [ADDR_W-1:0] address);
    in_item_t req;
    req.command = command;
    req.size    = size[SIZE_W-1:0];
    req.address = address;
    return req;
  endfunction

  // Mostly well-formed alloc/free traffic on a few favoured classes, some noise
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned roll;
    int unsigned pick;
    roll        = $urandom_range(0, 99);
    req.command = cmd_e'($urandom_range(0, 1));
    req.size    = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    req.address = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    if (roll < 8) begin
      // raw noise: any command, size and address
    end else if (roll < 14) begin
      req.size = roll[0] ? '0 : SIZE_W'($urandom_range(SIZE_CLASSES, (1 << SIZE_W) - 1));
    end else if (roll < 55 && live_addr_pool.size() != 0) begin
      pick        = $urandom_range(0, live_addr_pool.size() - 1);
      req.command = CMD_FREE;
      req.address = live_addr_pool[pick];
      req.size    = live_size_pool[pick];
      live_addr_pool.delete(pick);
      live_size_pool.delete(pick);
    end else begin
      req.command = CMD_ALLOC;
      case ($urandom_range(0, 3))
        0:       req.size = SIZE_W'($urandom_range(1, 8));
        1:       req.size = SIZE_W'(SIZE_CLASSES - 1);
        2:       req.size = SIZE_W'($urandom_range(1, SIZE_CLASSES - 1));
        default: req.size = SIZE_W'($urandom_range(9, 40));
      endcase
    end
    return req;
  endfunction

  // Offer one item, wait for it to be taken, then record its predicted result
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    bit          taken;
    out_item_t   outcome;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    outcome = serve_request(req);
    expected_results.push_back(outcome);
    last_status = outcome.status;
    if (req.command == CMD_ALLOC && outcome.status == STAT_OK && req.size < SIZE_CLASSES) begin
      live_addr_pool.push_back(outcome.address_res);
      live_size_pool.push_back(req.size);
    end
  endtask

  // Write both registers back to back; only called while the block is idle
  task automatic set_limits(input logic enable, input logic [LIMIT_W-1:0] cap);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_LIMIT_EN;
    cfg_data_i  <= {{(LIMIT_W-1){1'b0}}, enable};
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    limit_on    = enable;
    cfg_index_i <= CFG_BLOCK_LIMIT;
    cfg_data_i  <= cap;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    block_cap   = cap;
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering and wait, within a bound, for every owed result
  task automatic await_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failed = 1'b1;
      expected_results.delete();
    end
  endtask

  // Special sizes, list order and block limit boundaries
  task automatic test_directed_cases();
    set_limits(1'b1, 5'd0);
    send_request(make_request(CMD_ALLOC, 1, 16'hFFFF));
    send_request(make_request(CMD_ALLOC, 0, 16'h0000));
    send_request(make_request(CMD_FREE, 0, 16'hFFFF));
    send_request(make_request(CMD_ALLOC, 16'hFFFF, 16'h1234));
    send_request(make_request(CMD_FREE, SIZE_CLASSES, 16'h8001));
    send_request(make_request(CMD_FREE, SIZE_CLASSES - 1, 16'hFFFF));
    send_request(make_request(CMD_FREE, SIZE_CLASSES - 1, 16'h0000));
    // last freed comes back first, then the list runs dry with no block allowed
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'h5555));
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'hAAAA));
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'h0F0F));
    await_results();
    // one block: eight largest chunks fill it, the ninth hits the limit
    set_limits(1'b1, 5'd1);
    repeat (9) send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'hF0F0));
    send_request(make_request(CMD_ALLOC, 1, 16'h0001));
    await_results();
    // limit off: the request spills into a fresh block
    set_limits(1'b0, 5'd16);
    send_request(make_request(CMD_ALLOC, 9, 16'h7FFF));
    await_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic enable,
                                     input logic [LIMIT_W-1:0] cap);
    await_results();
    set_limits(enable, cap);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on = (i == 0) || ($urandom_range(0, 3) != 0);
      send_request(random_request());
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    await_results();
    idle_on         = 1'b0;
    hold_off_cycles = 150;
    repeat (30) send_request(random_request());
    idle_on = 1'b1;
  endtask

  // Use up every block, then check exhaustion and the limit taking precedence
  task automatic test_block_exhaustion();
    int unsigned tries;
    tries = 0;
    await_results();
    set_limits(1'b0, 5'd16);
    do begin
      send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1,
                                ADDR_W'($urandom_range(0, 16'hFFFF))));
      tries++;
    end while (last_status != STAT_EXHAUSTED && tries < 400);
    send_request(make_request(CMD_ALLOC, 4, 16'h0000));
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'hFFFF));
    await_results();
    set_limits(1'b1, 5'd16);
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 1, 16'h0000));
    send_request(make_request(CMD_ALLOC, SIZE_CLASSES - 2, 16'hFFFF));
  endtask

  // Result side: random stalls, then compare each taken item with the oldest prediction
  initial begin : result_checker
    out_item_t   got;
    out_item_t   want;
    int unsigned pause;
    bit          taken;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        pause           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        pause = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        got   = out_item_o;
        @(posedge clk_i);
      end while (!taken);
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: address_res %0d, status %0d",
               got.address_res, got.status);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.address_res !== want.address_res) begin
          $error("address_res: expected %0d, got %0d", want.address_res, got.address_res);
          failed = 1'b1;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failed = 1'b1;
        end
        if (got.bytes_reserved !== want.bytes_reserved) begin
          $error("bytes_reserved: expected %0d, got %0d",
                 want.bytes_reserved, got.bytes_reserved);
          failed = 1'b1;
        end
        if (got.request_count !== want.request_count) begin
          $error("request_count: expected %0d, got %0d",
                 want.request_count, got.request_count);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    foreach (head_table[i]) head_table[i] = '0;
    foreach (link_table[i]) link_table[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(150, 1'b1, 5'd16);
    test_random_traffic(150, 1'b1, LIMIT_W'($urandom_range(1, 5)));
    test_random_traffic(150, 1'b0, 5'd15);
    test_backpressure();
    test_block_exhaustion();
    test_random_traffic(200, 1'b1, 5'd16);
    test_random_traffic(200, 1'b0, 5'd0);

    await_results();
    repeat (FINAL_SETTLE) @(posedge clk_i);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
